FILE: sv/bpp_pkg.sv
`timescale 1ns / 1ps
// Package for the relativistic Boris particle pusher: Q16.16 types, constants
// and the fixed-point helper functions, saturating where they return Q16.16. Depends on nothing.
package bpp_pkg;

    typedef logic signed [31:0] q_t;
    typedef logic [63:0]        wide_t;

    localparam q_t QMAX = 32'sh7FFFFFFF;
    localparam q_t QMIN = 32'sh80000000;
    localparam q_t QONE = 32'sd65536;

    localparam int TS_W       = 31;
    localparam int GAMMA_W    = 31;
    localparam int RAD_W      = 64;
    localparam int T_NUM_W    = 48;
    localparam int T_QUO_W    = 33;
    localparam int F_NUM_W    = 34;
    localparam int F_QUO_W    = 18;
    localparam int SQRT_STEPS = 4;
    localparam int DIV_STEPS  = 4;

    localparam logic [TS_W-1:0]    TS_RESET  = 31'd65536;
    localparam logic [GAMMA_W-1:0] GAMMA_MIN = 31'd65536;
    localparam logic [F_NUM_W-1:0] F_NUM_TWO = 34'h2_0000_0000;
    localparam logic [F_QUO_W-1:0] F_QUO_MAX = 18'd131073;
    localparam wide_t              RAD_ONE   = 64'h1_0000_0000;

    typedef struct packed {
        q_t [2:0]             u;
        q_t [2:0]             ef;
        q_t [2:0]             bf;
        q_t                   h;
        q_t [2:0]             e;
        q_t [2:0]             um;
        q_t                   t;
        q_t [2:0]             b;
        q_t [2:0]             w;
        q_t [2:0]             c;
        q_t [2:0]             sq;
        logic [GAMMA_W-1:0]   g;
        logic [GAMMA_W-1:0]   den;
        logic [T_NUM_W-1:0]   nd;
        logic [F_QUO_W-1:0]   f;
        wide_t [8:0]          p;
        wide_t                s;
    } pt_t;

    function automatic q_t sat32(input logic signed [65:0] x);
        if (x > 66'sd2147483647) begin
            return QMAX;
        end
        else if (x < -66'sd2147483648) begin
            return QMIN;
        end
        return x[31:0];
    endfunction

    function automatic q_t qrnd(input logic signed [63:0] p);
        logic signed [65:0] x;
        x = p;
        x = x + 66'sd32768;
        return sat32(x >>> 16);
    endfunction

    function automatic q_t hround(input logic signed [63:0] p);
        logic signed [65:0] x;
        x = p;
        x = x + 66'sd65536;
        return sat32(x >>> 17);
    endfunction

    function automatic q_t qadd(input q_t a, input q_t b);
        logic signed [65:0] x;
        x = a;
        x = x + b;
        return sat32(x);
    endfunction

    function automatic q_t qsub(input q_t a, input q_t b);
        logic signed [65:0] x;
        x = a;
        x = x - b;
        return sat32(x);
    endfunction

    function automatic logic signed [63:0] qprod(input q_t a, input q_t b);
        return a * b;
    endfunction

    function automatic logic signed [63:0] qprodu(input q_t a, input logic [F_QUO_W-1:0] f);
        logic signed [F_QUO_W:0] fs;
        fs = {1'b0, f};
        return a * fs;
    endfunction

    function automatic logic [31:0] absu(input q_t a);
        return a[31] ? (~a + 32'd1) : a;
    endfunction

    function automatic wide_t abssq(input q_t a);
        logic [31:0] m;
        m = absu(a);
        return m * m;
    endfunction

    function automatic logic [GAMMA_W-1:0] sat_root(input logic [31:0] r);
        return r[31] ? {GAMMA_W{1'b1}} : r[GAMMA_W-1:0];
    endfunction

    function automatic q_t signq(input logic [T_QUO_W-1:0] q, input logic neg);
        logic signed [65:0] y;
        y = {33'd0, q};
        if (neg) begin
            y = -y;
        end
        return sat32(y);
    endfunction

endpackage

FILE: sv/bpp_if.sv
`timescale 1ns / 1ps
// Channel interfaces of the particle pusher: particle input, result output
// and the time step write channel. Depends on nothing.
interface bpp_particle_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] mom_x;
    logic signed [31:0] mom_y;
    logic signed [31:0] mom_z;
    logic signed [31:0] charge_mass_ratio;
    logic signed [31:0] efield_x;
    logic signed [31:0] efield_y;
    logic signed [31:0] efield_z;
    logic signed [31:0] bfield_x;
    logic signed [31:0] bfield_y;
    logic signed [31:0] bfield_z;

    modport source(output valid, mom_x, mom_y, mom_z, charge_mass_ratio, efield_x, efield_y,
                   efield_z, bfield_x, bfield_y, bfield_z, input ready);
    modport sink(input valid, mom_x, mom_y, mom_z, charge_mass_ratio, efield_x, efield_y,
                 efield_z, bfield_x, bfield_y, bfield_z, output ready);
endinterface

interface bpp_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] new_mom_x;
    logic signed [31:0] new_mom_y;
    logic signed [31:0] new_mom_z;
    logic [30:0]        lorentz_factor;

    modport source(output valid, new_mom_x, new_mom_y, new_mom_z, lorentz_factor, input ready);
    modport sink(input valid, new_mom_x, new_mom_y, new_mom_z, lorentz_factor, output ready);
endinterface

interface bpp_cfg_if;
    logic        valid;
    logic        ready;
    logic [30:0] time_step;

    modport source(output valid, time_step, input ready);
    modport sink(input valid, time_step, output ready);
endinterface

FILE: sv/bpp_stage.sv
`timescale 1ns / 1ps
// One pipeline register with valid/ready flow control for the pusher datapath.
// Depends on nothing.
module bpp_stage #(
    parameter int W = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [W-1:0] in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [W-1:0] out_data
);

    logic         v_reg;
    logic [W-1:0] d_reg;

    assign in_ready  = !v_reg || out_ready;
    assign out_valid = v_reg;
    assign out_data  = d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            d_reg <= in_data;
        end
    end

endmodule

FILE: sv/bpp_isqrt.sv
`timescale 1ns / 1ps
// Pipelined floor integer square root, STEPS result bits per stage, with a
// side payload carried alongside. Depends on nothing.
module bpp_isqrt #(
    parameter int RAD_W  = 64,
    parameter int SIDE_W = 32,
    parameter int STEPS  = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [RAD_W-1:0]     in_rad,
    input  logic [SIDE_W-1:0]    in_side,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [RAD_W/2-1:0]   out_root,
    output logic [SIDE_W-1:0]    out_side
);

    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 4;
    localparam int NSTG   = (ROOT_W + STEPS - 1) / STEPS;

    logic [NSTG-1:0]   v_reg;
    logic [NSTG:0]     rdy;
    logic [REM_W-1:0]  rem_reg   [NSTG];
    logic [ROOT_W-1:0] root_reg  [NSTG];
    logic [RAD_W-1:0]  rad_reg   [NSTG];
    logic [SIDE_W-1:0] side_reg  [NSTG];
    logic              src_v     [NSTG];
    logic [REM_W-1:0]  src_rem   [NSTG];
    logic [ROOT_W-1:0] src_root  [NSTG];
    logic [RAD_W-1:0]  src_rad   [NSTG];
    logic [SIDE_W-1:0] src_side  [NSTG];
    logic [REM_W-1:0]  rem_next  [NSTG];
    logic [ROOT_W-1:0] root_next [NSTG];
    logic [RAD_W-1:0]  rad_next  [NSTG];

    assign rdy[NSTG]  = out_ready;
    assign in_ready   = rdy[0];
    assign out_valid  = v_reg[NSTG-1];
    assign out_root   = root_reg[NSTG-1];
    assign out_side   = side_reg[NSTG-1];

    for (genvar k = 0; k < NSTG; k++)
    begin : g_stg
        if (k == 0)
        begin : g_first
            assign src_v[k]    = in_valid;
            assign src_rem[k]  = '0;
            assign src_root[k] = '0;
            assign src_rad[k]  = in_rad;
            assign src_side[k] = in_side;
        end
        else
        begin : g_next
            assign src_v[k]    = v_reg[k-1];
            assign src_rem[k]  = rem_reg[k-1];
            assign src_root[k] = root_reg[k-1];
            assign src_rad[k]  = rad_reg[k-1];
            assign src_side[k] = side_reg[k-1];
        end

        assign rdy[k] = !v_reg[k] || rdy[k+1];

        always_comb
        begin
            logic [REM_W-1:0]  acc;
            logic [REM_W-1:0]  trl;
            logic [REM_W-1:0]  rem;
            logic [ROOT_W-1:0] root;
            logic [RAD_W-1:0]  rad;
            rem  = src_rem[k];
            root = src_root[k];
            rad  = src_rad[k];
            for (int j = 0; j < STEPS; j++)
            begin
                if (k * STEPS + j < ROOT_W)
                begin
                    acc = {rem[REM_W-3:0], rad[RAD_W-1 -: 2]};
                    trl = {2'b00, root, 2'b01};
                    if (acc >= trl)
                    begin
                        rem  = acc - trl;
                        root = {root[ROOT_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem  = acc;
                        root = {root[ROOT_W-2:0], 1'b0};
                    end
                    rad = rad << 2;
                end
            end
            rem_next[k]  = rem;
            root_next[k] = root;
            rad_next[k]  = rad;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (rdy[k])
            begin
                v_reg[k] <= src_v[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[k] && src_v[k])
            begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                rad_reg[k]  <= rad_next[k];
                side_reg[k] <= src_side[k];
            end
        end
    end

endmodule

FILE: sv/bpp_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider for unsigned operands whose quotient is known to
// fit QUO_W bits; STEPS quotient bits per stage, side payload carried along.
module bpp_div #(
    parameter int NUM_W  = 48,
    parameter int DEN_W  = 31,
    parameter int QUO_W  = 33,
    parameter int SIDE_W = 32,
    parameter int STEPS  = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [NUM_W-1:0]  in_num,
    input  logic [DEN_W-1:0]  in_den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [QUO_W-1:0]  out_quo,
    output logic [SIDE_W-1:0] out_side
);

    localparam int NSTG = (QUO_W + STEPS - 1) / STEPS;

    logic [NSTG-1:0]   v_reg;
    logic [NSTG:0]     rdy;
    logic [DEN_W-1:0]  rem_reg  [NSTG];
    logic [QUO_W-1:0]  sh_reg   [NSTG];
    logic [DEN_W-1:0]  den_reg  [NSTG];
    logic [SIDE_W-1:0] side_reg [NSTG];
    logic              src_v    [NSTG];
    logic [DEN_W-1:0]  src_rem  [NSTG];
    logic [QUO_W-1:0]  src_sh   [NSTG];
    logic [DEN_W-1:0]  src_den  [NSTG];
    logic [SIDE_W-1:0] src_side [NSTG];
    logic [DEN_W-1:0]  rem_next [NSTG];
    logic [QUO_W-1:0]  sh_next  [NSTG];

    assign rdy[NSTG] = out_ready;
    assign in_ready  = rdy[0];
    assign out_valid = v_reg[NSTG-1];
    assign out_quo   = sh_reg[NSTG-1];
    assign out_side  = side_reg[NSTG-1];

    for (genvar k = 0; k < NSTG; k++)
    begin : g_stg
        if (k == 0)
        begin : g_first
            assign src_v[k]    = in_valid;
            assign src_rem[k]  = DEN_W'(in_num[NUM_W-1:QUO_W]);
            assign src_sh[k]   = in_num[QUO_W-1:0];
            assign src_den[k]  = in_den;
            assign src_side[k] = in_side;
        end
        else
        begin : g_next
            assign src_v[k]    = v_reg[k-1];
            assign src_rem[k]  = rem_reg[k-1];
            assign src_sh[k]   = sh_reg[k-1];
            assign src_den[k]  = den_reg[k-1];
            assign src_side[k] = side_reg[k-1];
        end

        assign rdy[k] = !v_reg[k] || rdy[k+1];

        always_comb
        begin
            logic [DEN_W:0]   acc;
            logic [DEN_W-1:0] rem;
            logic [QUO_W-1:0] sh;
            logic             qb;
            rem = src_rem[k];
            sh  = src_sh[k];
            for (int j = 0; j < STEPS; j++)
            begin
                if (k * STEPS + j < QUO_W)
                begin
                    acc = {rem, sh[QUO_W-1]};
                    if (acc >= {1'b0, src_den[k]})
                    begin
                        acc = acc - {1'b0, src_den[k]};
                        qb  = 1'b1;
                    end
                    else
                    begin
                        qb = 1'b0;
                    end
                    rem = acc[DEN_W-1:0];
                    sh  = {sh[QUO_W-2:0], qb};
                end
            end
            rem_next[k] = rem;
            sh_next[k]  = sh;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (rdy[k])
            begin
                v_reg[k] <= src_v[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy[k] && src_v[k])
            begin
                rem_reg[k]  <= rem_next[k];
                sh_reg[k]   <= sh_next[k];
                den_reg[k]  <= src_den[k];
                side_reg[k] <= src_side[k];
            end
        end
    end

endmodule

FILE: sv/boris_particle_pusher.sv
`timescale 1ns / 1ps
// Top level of the relativistic Boris particle pusher: datapath stages, two
// square root and two divider pipelines. Depends on bpp_pkg, bpp_if, bpp_stage,
// bpp_isqrt and bpp_div.
//
//   channel    role    transfer carries
//   particle   sink    momentum, charge to mass ratio, E and B at the particle
//   result     source  new momentum and Lorentz factor
//   cfg        sink    time step, unsigned Q15.16
//
// One particle is taken per cycle unless the result side stalls. At the default
// step counts there are 20 datapath stages, two 8-stage square roots, a 9-stage
// and a 5-stage divider. Reset clears every valid bit and sets the time step to
// 1.0. Each stage holds its item while the next stage is full and stalled, so
// bubbles close up and nothing is dropped or repeated.
module boris_particle_pusher #(
    parameter int SQRT_STEPS = bpp_pkg::SQRT_STEPS,
    parameter int DIV_STEPS  = bpp_pkg::DIV_STEPS
) (
    input  logic             clk,
    input  logic             rst_n,
    bpp_particle_if.sink     particle,
    bpp_result_if.source     result,
    bpp_cfg_if.sink          cfg
);

    localparam int NA   = 20;
    localparam int PT_W = $bits(bpp_pkg::pt_t);

    logic [bpp_pkg::TS_W-1:0] time_step_reg;

    logic          a_iv [NA];
    logic          a_ir [NA];
    logic          a_ov [NA];
    logic          a_or [NA];
    bpp_pkg::pt_t  a_id [NA];
    bpp_pkg::pt_t  a_od [NA];

    logic                         sq1_ov;
    logic [31:0]                  sq1_root;
    bpp_pkg::pt_t                 sq1_side;
    logic                         sq2_ov;
    logic [31:0]                  sq2_root;
    bpp_pkg::pt_t                 sq2_side;
    logic                         dv1_ov;
    logic [bpp_pkg::T_QUO_W-1:0]  dv1_quo;
    bpp_pkg::pt_t                 dv1_side;
    logic                         dv2_ov;
    logic [bpp_pkg::F_QUO_W-1:0]  dv2_quo;
    bpp_pkg::pt_t                 dv2_side;
    logic [bpp_pkg::F_NUM_W-1:0]  dv2_num;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg <= bpp_pkg::TS_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            time_step_reg <= cfg.time_step;
        end
    end

    for (genvar k = 0; k < NA; k++)
    begin : g_a
        bpp_stage #(
            .W(PT_W)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (a_iv[k]),
            .in_ready  (a_ir[k]),
            .in_data   (a_id[k]),
            .out_valid (a_ov[k]),
            .out_ready (a_or[k]),
            .out_data  (a_od[k])
        );
        if (k != 0 && k != 6 && k != 7 && k != 13 && k != 19)
        begin : g_link
            assign a_iv[k]   = a_ov[k-1];
            assign a_or[k-1] = a_ir[k];
        end
    end

    assign a_iv[0]        = particle.valid;
    assign particle.ready = a_ir[0];
    assign result.valid   = a_ov[NA-1];
    assign a_or[NA-1]     = result.ready;

    assign result.new_mom_x      = a_od[NA-1].u[0];
    assign result.new_mom_y      = a_od[NA-1].u[1];
    assign result.new_mom_z      = a_od[NA-1].u[2];
    assign result.lorentz_factor = a_od[NA-1].g;

    bpp_isqrt #(
        .RAD_W  (bpp_pkg::RAD_W),
        .SIDE_W (PT_W),
        .STEPS  (SQRT_STEPS)
    ) u_sqrt_mid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (a_ov[5]),
        .in_ready  (a_or[5]),
        .in_rad    (a_od[5].s),
        .in_side   (a_od[5]),
        .out_valid (sq1_ov),
        .out_ready (a_ir[6]),
        .out_root  (sq1_root),
        .out_side  (sq1_side)
    );
    assign a_iv[6] = sq1_ov;

    bpp_div #(
        .NUM_W  (bpp_pkg::T_NUM_W),
        .DEN_W  (bpp_pkg::GAMMA_W),
        .QUO_W  (bpp_pkg::T_QUO_W),
        .SIDE_W (PT_W),
        .STEPS  (DIV_STEPS)
    ) u_div_t (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (a_ov[6]),
        .in_ready  (a_or[6]),
        .in_num    (a_od[6].nd),
        .in_den    (a_od[6].g),
        .in_side   (a_od[6]),
        .out_valid (dv1_ov),
        .out_ready (a_ir[7]),
        .out_quo   (dv1_quo),
        .out_side  (dv1_side)
    );
    assign a_iv[7] = dv1_ov;

    assign dv2_num = bpp_pkg::F_NUM_TWO + bpp_pkg::F_NUM_W'(a_od[12].den >> 1);

    bpp_div #(
        .NUM_W  (bpp_pkg::F_NUM_W),
        .DEN_W  (bpp_pkg::GAMMA_W),
        .QUO_W  (bpp_pkg::F_QUO_W),
        .SIDE_W (PT_W),
        .STEPS  (DIV_STEPS)
    ) u_div_f (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (a_ov[12]),
        .in_ready  (a_or[12]),
        .in_num    (dv2_num),
        .in_den    (a_od[12].den),
        .in_side   (a_od[12]),
        .out_valid (dv2_ov),
        .out_ready (a_ir[13]),
        .out_quo   (dv2_quo),
        .out_side  (dv2_side)
    );
    assign a_iv[13] = dv2_ov;

    bpp_isqrt #(
        .RAD_W  (bpp_pkg::RAD_W),
        .SIDE_W (PT_W),
        .STEPS  (SQRT_STEPS)
    ) u_sqrt_end (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (a_ov[18]),
        .in_ready  (a_or[18]),
        .in_rad    (a_od[18].s),
        .in_side   (a_od[18]),
        .out_valid (sq2_ov),
        .out_ready (a_ir[19]),
        .out_root  (sq2_root),
        .out_side  (sq2_side)
    );
    assign a_iv[19] = sq2_ov;

    always_comb
    begin
        bpp_pkg::pt_t x;
        bpp_pkg::q_t  d;

        // Half kick factor: raw product of time step and charge to mass ratio.
        x       = '0;
        x.u[0]  = particle.mom_x;
        x.u[1]  = particle.mom_y;
        x.u[2]  = particle.mom_z;
        x.ef[0] = particle.efield_x;
        x.ef[1] = particle.efield_y;
        x.ef[2] = particle.efield_z;
        x.bf[0] = particle.bfield_x;
        x.bf[1] = particle.bfield_y;
        x.bf[2] = particle.bfield_z;
        x.p[0]  = bpp_pkg::qprod({1'b0, time_step_reg}, particle.charge_mass_ratio);
        a_id[0] = x;

        x       = a_od[0];
        x.h     = bpp_pkg::hround(x.p[0]);
        a_id[1] = x;

        x = a_od[1];
        for (int i = 0; i < 3; i++)
        begin
            x.p[i] = bpp_pkg::qprod(x.ef[i], x.h);
        end
        a_id[2] = x;

        // First half kick.
        x = a_od[2];
        for (int i = 0; i < 3; i++)
        begin
            x.e[i]  = bpp_pkg::qrnd(x.p[i]);
            x.um[i] = bpp_pkg::qadd(x.u[i], x.e[i]);
        end
        a_id[3] = x;

        x = a_od[3];
        for (int i = 0; i < 3; i++)
        begin
            x.p[i] = bpp_pkg::abssq(x.um[i]);
        end
        a_id[4] = x;

        x       = a_od[4];
        x.s     = bpp_pkg::RAD_ONE + x.p[0] + x.p[1] + x.p[2];
        a_id[5] = x;

        x       = sq1_side;
        x.g     = bpp_pkg::sat_root(sq1_root);
        x.nd    = {bpp_pkg::absu(x.h), 16'h0000} + bpp_pkg::T_NUM_W'(x.g >> 1);
        a_id[6] = x;

        x       = dv1_side;
        x.t     = bpp_pkg::signq(dv1_quo, x.h[31]);
        a_id[7] = x;

        x = a_od[7];
        for (int i = 0; i < 3; i++)
        begin
            x.p[i] = bpp_pkg::qprod(x.bf[i], x.t);
        end
        a_id[8] = x;

        x = a_od[8];
        for (int i = 0; i < 3; i++)
        begin
            x.b[i] = bpp_pkg::qrnd(x.p[i]);
        end
        a_id[9] = x;

        // Products for u- cross b and for the squares of b.
        x      = a_od[9];
        x.p[0] = bpp_pkg::qprod(x.um[1], x.b[2]);
        x.p[1] = bpp_pkg::qprod(x.um[2], x.b[1]);
        x.p[2] = bpp_pkg::qprod(x.um[2], x.b[0]);
        x.p[3] = bpp_pkg::qprod(x.um[0], x.b[2]);
        x.p[4] = bpp_pkg::qprod(x.um[0], x.b[1]);
        x.p[5] = bpp_pkg::qprod(x.um[1], x.b[0]);
        for (int i = 0; i < 3; i++)
        begin
            x.p[6+i] = bpp_pkg::qprod(x.b[i], x.b[i]);
        end
        a_id[10] = x;

        x = a_od[10];
        for (int i = 0; i < 3; i++)
        begin
            x.w[i]  = bpp_pkg::qsub(bpp_pkg::qrnd(x.p[2*i]), bpp_pkg::qrnd(x.p[2*i+1]));
            x.sq[i] = bpp_pkg::qrnd(x.p[6+i]);
        end
        a_id[11] = x;

        x = a_od[11];
        for (int i = 0; i < 3; i++)
        begin
            x.w[i] = bpp_pkg::qadd(x.um[i], x.w[i]);
        end
        d = bpp_pkg::qadd(bpp_pkg::QONE,
                          bpp_pkg::qadd(bpp_pkg::qadd(x.sq[0], x.sq[1]), x.sq[2]));
        if (d < bpp_pkg::QONE)
        begin
            d = bpp_pkg::QONE;
        end
        x.den    = d[bpp_pkg::GAMMA_W-1:0];
        a_id[12] = x;

        // Products for w cross b.
        x        = dv2_side;
        x.f      = dv2_quo;
        x.p[0]   = bpp_pkg::qprod(x.w[1], x.b[2]);
        x.p[1]   = bpp_pkg::qprod(x.w[2], x.b[1]);
        x.p[2]   = bpp_pkg::qprod(x.w[2], x.b[0]);
        x.p[3]   = bpp_pkg::qprod(x.w[0], x.b[2]);
        x.p[4]   = bpp_pkg::qprod(x.w[0], x.b[1]);
        x.p[5]   = bpp_pkg::qprod(x.w[1], x.b[0]);
        a_id[13] = x;

        x = a_od[13];
        for (int i = 0; i < 3; i++)
        begin
            x.c[i] = bpp_pkg::qsub(bpp_pkg::qrnd(x.p[2*i]), bpp_pkg::qrnd(x.p[2*i+1]));
        end
        a_id[14] = x;

        x = a_od[14];
        for (int i = 0; i < 3; i++)
        begin
            x.p[i] = bpp_pkg::qprodu(x.c[i], x.f);
        end
        a_id[15] = x;

        // Rotation result and second half kick.
        x = a_od[15];
        for (int i = 0; i < 3; i++)
        begin
            x.um[i] = bpp_pkg::qadd(x.um[i], bpp_pkg::qrnd(x.p[i]));
            x.u[i]  = bpp_pkg::qadd(x.um[i], x.e[i]);
        end
        a_id[16] = x;

        x = a_od[16];
        for (int i = 0; i < 3; i++)
        begin
            x.p[i] = bpp_pkg::abssq(x.u[i]);
        end
        a_id[17] = x;

        x        = a_od[17];
        x.s      = bpp_pkg::RAD_ONE + x.p[0] + x.p[1] + x.p[2];
        a_id[18] = x;

        x        = sq2_side;
        x.g      = bpp_pkg::sat_root(sq2_root);
        a_id[19] = x;
    end

`ifndef SYNTHESIS
    a_gamma_min: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.lorentz_factor >= bpp_pkg::GAMMA_MIN)
        else $error("Lorentz factor below one on a result.");

    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg.valid && cfg.ready) |=> time_step_reg == $past(cfg.time_step))
        else $error("Time step register missed a write transfer.");

    a_t_range: assert property (@(posedge clk) disable iff (!rst_n)
        a_ov[6] |-> (bpp_pkg::GAMMA_W'(a_od[6].nd >> bpp_pkg::T_QUO_W) < a_od[6].g))
        else $error("Quotient of h over gamma does not fit the divider.");

    a_f_range: assert property (@(posedge clk) disable iff (!rst_n)
        dv2_ov |-> dv2_quo <= bpp_pkg::F_QUO_MAX)
        else $error("Rotation scale factor out of range.");
`endif

endmodule

FILE: verif/boris_particle_pusher_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the relativistic Boris particle pusher: drives
// particle and time step transfers and compares each result with a predictor or a
// stored expected value. Depends on bpp_pkg, bpp_if and boris_particle_pusher.
module boris_particle_pusher_tb;

    typedef struct packed {
        logic signed [31:0] mx, my, mz, qm, ex, ey, ez, bx, by, bz;
    } particle_t;

    typedef struct packed {
        logic signed [31:0] nx, ny, nz;
        logic [30:0]        gam;
    } push_t;

    typedef struct {
        particle_t p;
        logic      known;
        push_t     r;
    } row_t;

    localparam longint LIMIT   = 1000000;
    localparam int     LATENCY = 80;
    localparam logic signed [31:0] PMAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] PMIN = 32'sh80000000;
    localparam logic signed [31:0] PONE = 32'sh00010000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    longint cycles = 0;
    int errors = 0;
    int pushed = 0;
    int checked = 0;
    int send_idle = 0;
    int recv_stall = 0;
    int hold_cycles = 0;
    logic [30:0] step_size = 31'd65536;
    push_t expected_pushes[$];

    bpp_particle_if particle ();
    bpp_result_if   result ();
    bpp_cfg_if      cfg ();

    boris_particle_pusher dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .particle(particle),
        .result  (result),
        .cfg     (cfg)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic longint clamp(input longint x);
        if (x > 64'sd2147483647)
        begin
            return 64'sd2147483647;
        end
        if (x < -64'sd2147483648)
        begin
            return -64'sd2147483648;
        end
        return x;
    endfunction

    function automatic longint fdiv2(input longint x, input int s);
        return x >>> s;
    endfunction

    function automatic longint fmul(input longint a, input longint b);
        return clamp(fdiv2(a * b + 32768, 16));
    endfunction

    function automatic longint fcross(input longint a1, b1, a2, b2);
        return clamp(fmul(a1, b1) - fmul(a2, b2));
    endfunction

    function automatic longint gamma_of(input longint x, y, z);
        logic [63:0] s, r, bt;
        s = 64'h1_0000_0000 + x * x + y * y + z * z;
        r = 0;
        bt = 64'h4000_0000_0000_0000;
        while (bt > s)
        begin
            bt = bt >> 2;
        end
        while (bt != 0)
        begin
            if (s >= r + bt)
            begin
                s = s - (r + bt);
                r = (r >> 1) + bt;
            end
            else
            begin
                r = r >> 1;
            end
            bt = bt >> 2;
        end
        return (r > 64'd2147483647) ? 64'sd2147483647 : longint'(r);
    endfunction

    function automatic push_t boris_step(input particle_t p, input logic [30:0] dt);
        longint u[3], e[3], b[3], um[3], w[3], c[3];
        longint h, g, t, m, q, den, f, bsq;
        push_t r;
        u[0] = p.mx; u[1] = p.my; u[2] = p.mz;
        e[0] = p.ex; e[1] = p.ey; e[2] = p.ez;
        b[0] = p.bx; b[1] = p.by; b[2] = p.bz;
        h = clamp(fdiv2(longint'(dt) * longint'(p.qm) + 65536, 17));
        for (int i = 0; i < 3; i++)
        begin
            e[i] = fmul(e[i], h);
            um[i] = clamp(u[i] + e[i]);
        end
        g = gamma_of(um[0], um[1], um[2]);
        m = h < 0 ? -h : h;
        q = (m * 65536 + g / 2) / g;
        t = clamp(h < 0 ? -q : q);
        for (int i = 0; i < 3; i++)
        begin
            b[i] = fmul(b[i], t);
        end
        w[0] = clamp(um[0] + fcross(um[1], b[2], um[2], b[1]));
        w[1] = clamp(um[1] + fcross(um[2], b[0], um[0], b[2]));
        w[2] = clamp(um[2] + fcross(um[0], b[1], um[1], b[0]));
        bsq = clamp(clamp(fmul(b[0], b[0]) + fmul(b[1], b[1])) + fmul(b[2], b[2]));
        den = clamp(65536 + bsq);
        if (den < 65536)
        begin
            den = 65536;
        end
        f = ((64'sd1 <<< 33) + den / 2) / den;
        c[0] = fcross(w[1], b[2], w[2], b[1]);
        c[1] = fcross(w[2], b[0], w[0], b[2]);
        c[2] = fcross(w[0], b[1], w[1], b[0]);
        for (int i = 0; i < 3; i++)
        begin
            um[i] = clamp(um[i] + fmul(c[i], f));
            u[i] = clamp(um[i] + e[i]);
        end
        r.nx = u[0][31:0];
        r.ny = u[1][31:0];
        r.nz = u[2][31:0];
        g = gamma_of(u[0], u[1], u[2]);
        r.gam = g[30:0];
        return r;
    endfunction

    function automatic logic signed [31:0] rand_q();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 3) == 0 ? PMAX : PMIN;
            default: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
        endcase
    endfunction

    function automatic particle_t rand_particle();
        particle_t p;
        p.mx = rand_q(); p.my = rand_q(); p.mz = rand_q(); p.qm = rand_q();
        p.ex = rand_q(); p.ey = rand_q(); p.ez = rand_q();
        p.bx = rand_q(); p.by = rand_q(); p.bz = rand_q();
        return p;
    endfunction

    task automatic wait_drained();
        while (expected_pushes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic write_step(input logic [30:0] dt);
        cfg.valid <= 1'b1;
        cfg.time_step <= dt;
        @(posedge clk);
        while (!cfg.ready)
        begin
            @(posedge clk);
        end
        cfg.valid <= 1'b0;
        step_size = dt;
    endtask

    // Driving of the particle fields is kept in one place.
    task automatic offer(input particle_t p, input logic known, input push_t r);
        while ($urandom_range(0, 99) < send_idle)
        begin
            particle.valid <= 1'b0;
            @(posedge clk);
        end
        particle.valid <= 1'b1;
        particle.mom_x <= p.mx;
        particle.mom_y <= p.my;
        particle.mom_z <= p.mz;
        particle.charge_mass_ratio <= p.qm;
        particle.efield_x <= p.ex;
        particle.efield_y <= p.ey;
        particle.efield_z <= p.ez;
        particle.bfield_x <= p.bx;
        particle.bfield_y <= p.by;
        particle.bfield_z <= p.bz;
        @(posedge clk);
        while (!particle.ready)
        begin
            @(posedge clk);
        end
        expected_pushes.push_back(known ? r : boris_step(p, step_size));
        pushed++;
    endtask

    task automatic run_random(input int n);
        for (int i = 0; i < n; i++)
        begin
            offer(rand_particle(), 1'b0, '0);
        end
        particle.valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        push_t got, want;
        if (rst_n && result.valid && result.ready)
        begin
            got.nx = result.new_mom_x;
            got.ny = result.new_mom_y;
            got.nz = result.new_mom_z;
            got.gam = result.lorentz_factor;
            if (expected_pushes.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end
            else
            begin
                want = expected_pushes.pop_front();
                checked++;
                if (got !== want)
                begin
                    $display("%0t: mismatch expected %h %h %h %h actual %h %h %h %h", $time,
                             want.nx, want.ny, want.nz, want.gam,
                             got.nx, got.ny, got.nz, got.gam);
                    errors++;
                end
            end
        end
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            result.ready <= 1'b0;
        end
        else
        begin
            result.ready <= ($urandom_range(0, 99) >= recv_stall);
        end
    end

    initial
    begin
        row_t rows[$];
        row_t rw;
        particle_t z;
        push_t still;
        z = '0;
        particle.valid = 1'b0;
        {particle.mom_x, particle.mom_y, particle.mom_z, particle.charge_mass_ratio} = '0;
        {particle.efield_x, particle.efield_y, particle.efield_z} = '0;
        {particle.bfield_x, particle.bfield_y, particle.bfield_z} = '0;
        cfg.valid = 1'b0;
        cfg.time_step = '0;
        result.ready = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A particle at rest in zero fields stays at rest with gamma one.
        rw.p = z; rw.known = 1'b1; rw.r = '{0, 0, 0, 31'd65536}; rows.push_back(rw);
        // Without charge the momentum passes through unchanged.
        rw.p = z; rw.p.mx = PONE; rw.p.ex = PMAX; rw.p.bz = PMAX;
        rw.r = '{PONE, 0, 0, 31'd92681}; rows.push_back(rw);
        rw.p = z; rw.p.mx = PMAX; rw.p.my = PMIN; rw.p.mz = PMAX;
        rw.r = '{PMAX, PMIN, PMAX, 31'h7FFFFFFF}; rows.push_back(rw);
        rw.known = 1'b0;
        rw.p = '{PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX}; rows.push_back(rw);
        rw.p = '{PMIN, PMIN, PMIN, PMIN, PMIN, PMIN, PMIN, PMIN, PMIN, PMIN}; rows.push_back(rw);
        rw.p = '{-1, 1, -1, PMIN, PMAX, PMIN, PMAX, PMIN, PMAX, PMIN}; rows.push_back(rw);
        rw.p = '{0, 0, 0, PONE, PONE, 0, 0, 0, 0, PONE}; rows.push_back(rw);
        rw.p = '{PONE, 0, 0, PONE, 0, 0, 0, 0, 0, PONE <<< 3}; rows.push_back(rw);
        rw.p = '{-1, -1, -1, -1, -1, -1, -1, -1, -1, -1}; rows.push_back(rw);
        rw.p = '{32'sh5555AAAA, 32'shAAAA5555, 32'sh0F0F0F0F, 32'shF0F0F0F0,
                 32'sh33333333, 32'shCCCCCCCC, 32'sh12345678, 32'shEDCBA987,
                 32'sh00FF00FF, 32'shFF00FF00}; rows.push_back(rw);
        foreach (rows[i])
        begin
            offer(rows[i].p, rows[i].known, rows[i].r);
        end
        particle.valid <= 1'b0;
        wait_drained();

        write_step(31'd0);
        run_random(60);
        wait_drained();
        write_step(31'h7FFFFFFF);
        run_random(60);
        wait_drained();
        write_step(31'd1);
        run_random(40);
        wait_drained();

        for (int ph = 0; ph < 4; ph++)
        begin
            write_step(31'($urandom_range(1, 32'h0004_0000)));
            send_idle = (ph == 1 || ph == 3) ? (ph == 1 ? 48 : 19) : 0;
            recv_stall = (ph == 2 || ph == 3) ? (ph == 2 ? 48 : 19) : 0;
            if (ph == 0)
            begin
                hold_cycles = 300;
            end
            run_random(180);
            wait_drained();
        end

        $display("Pushed %0d particles through several time steps, %0d results checked.",
                 pushed, checked);
        if (errors == 0 && expected_pushes.size() == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/bpp_pkg.sv
sv/bpp_if.sv
sv/bpp_stage.sv
sv/bpp_isqrt.sv
sv/bpp_div.sv
sv/boris_particle_pusher.sv
verif/boris_particle_pusher_tb.sv
